// ===== hw/rtl/ist_pkg.sv =====
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants of the INI stream tokenizer
// Transaction payloads, byte classes, parser states and token codes.
// ----------------------------------------------------------------------------
package ist_pkg;

	// Default length limits.
	localparam int KEY_MAX_DEF     = 127;
	localparam int VALUE_MAX_DEF   = 255;
	localparam int SECTION_MAX_DEF = 127;

	// Depth of the queue between the classifier and the parser.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] PAIR_COUNT_MAX = 16'hFFFF;

	// Character constants.
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_EQUALS    = 8'h3D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_PERIOD    = 8'h2E;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;

	// Command codes of an input item.
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_EOF  = 1'b1;

	// Token kinds.
	typedef enum logic [2:0] {
		KIND_SECT_START = 3'd0,
		KIND_SECT_CHAR  = 3'd1,
		KIND_SECT_END   = 3'd2,
		KIND_KEY_CHAR   = 3'd3,
		KIND_VAL_CHAR   = 3'd4,
		KIND_PAIR_END   = 3'd5,
		KIND_ERROR      = 3'd6,
		KIND_DONE       = 3'd7
	} kind_t;

	// Error codes.
	typedef enum logic [1:0] {
		ERR_BAD_KEY   = 2'd0,
		ERR_NO_DELIM  = 2'd1,
		ERR_EMPTY_VAL = 2'd2,
		ERR_TOO_LONG  = 2'd3
	} err_t;

	// Parser states.
	typedef enum logic [2:0] {
		ST_PRE_KEY  = 3'd0,
		ST_COMMENT  = 3'd1,
		ST_KEY      = 3'd2,
		ST_POST_KEY = 3'd3,
		ST_PRE_VAL  = 3'd4,
		ST_VAL      = 3'd5,
		ST_SECTION  = 3'd6
	} parse_state_t;

	// Input transaction.
	typedef struct packed {
		logic       cmd;
		logic [7:0] char_in;
	} item_t;

	// Output transaction.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  char_out;
		logic [6:0]  key_length;
		logic [7:0]  value_length;
		logic [1:0]  error_code;
		logic        file_ok;
		logic [15:0] pair_count;
	} token_t;

	// Classified byte, as queued for the parser.
	typedef struct packed {
		logic       eof;
		logic       bslash;
		logic       cr;
		logic       nl;
		logic       key_char;
		logic       blank;
		logic       open;
		logic       close;
		logic       comment;
		logic       delim;
		logic [7:0] ch;
	} cls_t;

endpackage

// ===== hw/rtl/ini_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// ini_stream_tokenizer: streaming INI text tokenizer
// Classifies text bytes, queues them and parses them into section, key,
// value, pair-end, error and done tokens.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-----------------------
//   item     | in        | item_valid / item_stall  | item_t  (cmd, char_in)
//   token    | out       | token_valid / token_stall| token_t (kind .. count)
//
// One byte per cycle is taken while the queue is not full; the parse machine
// updates its state registers once per popped byte, so one transaction per
// cycle while the output is not stalled. A byte passes through a queue entry
// before its token is loaded into the token register.
// The four-entry byte queue keeps taking input while a token waits.
// Reset clears the parse state, queue pointers and the token valid flag.
// item_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module ini_stream_tokenizer import ist_pkg::*; #(
	parameter int KEY_MAX     = KEY_MAX_DEF,
	parameter int VALUE_MAX   = VALUE_MAX_DEF,
	parameter int SECTION_MAX = SECTION_MAX_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	output logic   item_stall,
	input  item_t  item,
	output logic   token_valid,
	input  logic   token_stall,
	output token_t token
);

	logic push;
	cls_t push_data;
	logic pop;
	logic full;
	logic not_empty;
	cls_t head;

	// Classifier.
	ist_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (full),
		.push       (push),
		.push_data  (push_data)
	);

	// Byte queue.
	ist_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	// Parser.
	ist_back #(
		.KEY_MAX     (KEY_MAX),
		.VALUE_MAX   (VALUE_MAX),
		.SECTION_MAX (SECTION_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.q_head      (head),
		.pop         (pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token       (token)
	);

endmodule

// ===== hw/rtl/ist_front.sv =====
// ----------------------------------------------------------------------------
// ist_front: input side of the INI stream tokenizer
// Accepts input transactions and classifies each byte for the parser.
// ----------------------------------------------------------------------------
module ist_front import ist_pkg::*; (
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	input  logic  queue_full,
	output logic  push,
	output cls_t  push_data
);

	logic [7:0] c;

	assign c = item.char_in;

	// Stall only when the queue has no room left.
	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;

	// Byte classification.
	always_comb begin
		push_data.eof      = (item.cmd == CMD_EOF);
		push_data.bslash   = (c == CH_BACKSLASH);
		push_data.cr       = (c == CH_CR);
		push_data.nl       = (c == CH_LF);
		push_data.key_char = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDERSCORE) || (c == CH_MINUS) ||
			(c == CH_PERIOD);
		push_data.blank    = (c == CH_SPACE) || (c == CH_TAB);
		push_data.open     = (c == CH_LBRACKET);
		push_data.close    = (c == CH_RBRACKET);
		push_data.comment  = (c == CH_SEMICOLON) || (c == CH_HASH);
		push_data.delim    = (c == CH_COLON) || (c == CH_EQUALS);
		push_data.ch       = c;
	end

endmodule

// ===== hw/rtl/ist_queue.sv =====
// ----------------------------------------------------------------------------
// ist_queue: queue of classified bytes
// Decouples the classifier from the parser so that each side stalls alone.
// ----------------------------------------------------------------------------
module ist_queue import ist_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output cls_t head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cls_t          entries_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
`endif

endmodule

// ===== hw/rtl/ist_back.sv =====
// ----------------------------------------------------------------------------
// ist_back: parser of the INI stream tokenizer
// Runs the seven-state parse machine on queued bytes and registers tokens.
// ----------------------------------------------------------------------------
module ist_back import ist_pkg::*; #(
	parameter int KEY_MAX     = KEY_MAX_DEF,
	parameter int VALUE_MAX   = VALUE_MAX_DEF,
	parameter int SECTION_MAX = SECTION_MAX_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_not_empty,
	input  cls_t   q_head,
	output logic   pop,
	output logic   token_valid,
	input  logic   token_stall,
	output token_t token
);

	localparam int KLW = $clog2(KEY_MAX + 1);
	localparam int VLW = $clog2(VALUE_MAX + 1);
	localparam int SLW = $clog2(SECTION_MAX + 1);

	parse_state_t   state_q, state_d;
	logic           esc_q, esc_d;
	logic           err_q, err_d;
	logic [KLW-1:0] key_len_q, key_len_d;
	logic [VLW-1:0] val_len_q, val_len_d;
	logic [VLW-1:0] trim_len_q, trim_len_d;
	logic [SLW-1:0] sect_len_q, sect_len_d;
	logic [15:0]    pairs_q, pairs_d;

	logic           res_valid;
	token_t         res;
	logic           out_valid_q;
	token_t         out_q;
	cls_t           b;

	assign b           = q_head;
	assign pop         = q_not_empty && (!out_valid_q || !token_stall);
	assign token_valid = out_valid_q;
	assign token       = out_q;

	// Next state and token for the byte at the head of the queue.
	always_comb begin
		state_d    = state_q;
		esc_d      = esc_q;
		err_d      = err_q;
		key_len_d  = key_len_q;
		val_len_d  = val_len_q;
		trim_len_d = trim_len_q;
		sect_len_d = sect_len_q;
		pairs_d    = pairs_q;
		res_valid  = 1'b0;
		res        = '0;

		priority if (b.eof) begin
			res_valid     = 1'b1;
			res.kind      = KIND_DONE;
			res.file_ok   = !err_q;
			res.pair_count = pairs_q;
			state_d    = ST_PRE_KEY;
			esc_d      = 1'b0;
			err_d      = 1'b0;
			key_len_d  = '0;
			val_len_d  = '0;
			trim_len_d = '0;
			sect_len_d = '0;
			pairs_d    = '0;
		end else if (err_q) begin
			// Bytes after an error are dropped until end of file.
		end else if (!esc_q && b.bslash) begin
			esc_d = 1'b1;
		end else if (b.cr) begin
			// Carriage returns are dropped, even when escaped.
		end else begin
			unique case (state_q)
				ST_PRE_KEY: begin
					if (esc_q || b.key_char) begin
						esc_d = 1'b0;
						if (!(esc_q && b.nl)) begin
							key_len_d    = KLW'(1);
							val_len_d    = '0;
							trim_len_d   = '0;
							state_d      = ST_KEY;
							res_valid    = 1'b1;
							res.kind     = KIND_KEY_CHAR;
							res.char_out = b.ch;
						end
					end else if (b.open) begin
						sect_len_d = '0;
						state_d    = ST_SECTION;
						res_valid  = 1'b1;
						res.kind   = KIND_SECT_START;
					end else if (b.comment) begin
						state_d = ST_COMMENT;
					end
				end
				ST_COMMENT: begin
					if (b.nl) begin
						if (esc_q) begin
							esc_d = 1'b0;
						end else begin
							state_d = ST_PRE_KEY;
						end
					end
				end
				ST_KEY: begin
					if (esc_q || b.key_char) begin
						esc_d = 1'b0;
						if (!(esc_q && b.nl)) begin
							res_valid = 1'b1;
							if (key_len_q >= KLW'(KEY_MAX)) begin
								err_d          = 1'b1;
								res.kind       = KIND_ERROR;
								res.error_code = ERR_TOO_LONG;
							end else begin
								key_len_d    = key_len_q + 1'b1;
								res.kind     = KIND_KEY_CHAR;
								res.char_out = b.ch;
							end
						end
					end else if (b.blank) begin
						state_d = ST_POST_KEY;
					end else if (b.delim) begin
						state_d = ST_PRE_VAL;
					end else begin
						err_d          = 1'b1;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_BAD_KEY;
					end
				end
				ST_POST_KEY: begin
					if (b.delim) begin
						state_d = ST_PRE_VAL;
					end else if (b.nl) begin
						if (!esc_q) begin
							err_d          = 1'b1;
							res_valid      = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_NO_DELIM;
						end else begin
							esc_d = 1'b0;
						end
					end
				end
				ST_PRE_VAL, ST_VAL: begin
					if (esc_q || (!b.nl && !b.comment &&
						!(state_q == ST_PRE_VAL && b.blank))) begin
						// Value character, with the trimmed length tracked.
						esc_d     = 1'b0;
						state_d   = ST_VAL;
						res_valid = 1'b1;
						if (val_len_q >= VLW'(VALUE_MAX)) begin
							err_d          = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_TOO_LONG;
						end else begin
							val_len_d = val_len_q + 1'b1;
							if (!b.blank) begin
								trim_len_d = val_len_q + 1'b1;
							end
							res.kind     = KIND_VAL_CHAR;
							res.char_out = b.ch;
						end
					end else if (state_q == ST_PRE_VAL) begin
						if (b.nl) begin
							err_d          = 1'b1;
							res_valid      = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_EMPTY_VAL;
						end
					end else begin
						// End of the value: report the pair.
						res_valid        = 1'b1;
						res.kind         = KIND_PAIR_END;
						res.key_length   = 7'(key_len_q);
						res.value_length = 8'(trim_len_q);
						if (pairs_q != PAIR_COUNT_MAX) begin
							pairs_d = pairs_q + 1'b1;
						end
						key_len_d  = '0;
						val_len_d  = '0;
						trim_len_d = '0;
						state_d    = b.nl ? ST_PRE_KEY : ST_COMMENT;
					end
				end
				ST_SECTION: begin
					res_valid = 1'b1;
					if (esc_q || !b.close) begin
						esc_d = 1'b0;
						if (sect_len_q >= SLW'(SECTION_MAX)) begin
							err_d          = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_TOO_LONG;
						end else begin
							sect_len_d   = sect_len_q + 1'b1;
							res.kind     = KIND_SECT_CHAR;
							res.char_out = b.ch;
						end
					end else begin
						state_d  = ST_PRE_KEY;
						res.kind = KIND_SECT_END;
					end
				end
				default: begin
					state_d = ST_PRE_KEY;
				end
			endcase
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_PRE_KEY;
			esc_q      <= 1'b0;
			err_q      <= 1'b0;
			key_len_q  <= '0;
			val_len_q  <= '0;
			trim_len_q <= '0;
			sect_len_q <= '0;
			pairs_q    <= '0;
		end else if (pop) begin
			state_q    <= state_d;
			esc_q      <= esc_d;
			err_q      <= err_d;
			key_len_q  <= key_len_d;
			val_len_q  <= val_len_d;
			trim_len_q <= trim_len_d;
			sect_len_q <= sect_len_d;
			pairs_q    <= pairs_d;
		end
	end

	// Output register: loads on a pop, empties when its transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= res_valid;
		end else if (out_valid_q && !token_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_key_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_len_q <= KLW'(KEY_MAX))
		else $error("key length beyond limit");
	a_trim_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		trim_len_q <= val_len_q)
		else $error("trimmed value length exceeds value length");
	a_sect_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sect_len_q <= SLW'(SECTION_MAX))
		else $error("section length beyond limit");
	a_quiet_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && err_q && res_valid) |-> (res.kind == KIND_DONE))
		else $error("token other than done after an error");
`endif

endmodule

// ===== verif/ist_token_checker.sv =====
// ----------------------------------------------------------------------------
// ist_token_checker: token checker for the INI stream tokenizer
// Follows every input transaction with its own copy of the parse machine and
// compares each output transaction, field by field, with the oldest token
// that the machine produced.
// ----------------------------------------------------------------------------
module ist_token_checker import ist_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	input  logic   item_stall,
	input  item_t  item,
	input  logic   token_valid,
	input  logic   token_stall,
	input  token_t token,
	output int     mismatches,
	output int     tokens_due_count
);

	// Parse machine state as this checker tracks it.
	parse_state_t scan_state;
	bit           escape_armed;
	bit           error_latched;
	int unsigned  key_count;
	int unsigned  value_count;
	int unsigned  value_kept;
	int unsigned  section_count;
	int unsigned  pair_total;

	// Tokens the block still owes, oldest first.
	token_t tokens_due[$];

	function automatic bit is_blank_byte(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit is_key_byte(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
			|| c == CH_UNDERSCORE || c == CH_MINUS || c == CH_PERIOD;
	endfunction

	function automatic void clear_parser();
		scan_state    = ST_PRE_KEY;
		escape_armed  = 1'b0;
		error_latched = 1'b0;
		key_count     = 0;
		value_count   = 0;
		value_kept    = 0;
		section_count = 0;
		pair_total    = 0;
	endfunction

	// An error also silences the rest of the file.
	function automatic token_t error_token(err_t code);
		token_t t;
		t             = '0;
		error_latched = 1'b1;
		t.kind        = KIND_ERROR;
		t.error_code  = code;
		return t;
	endfunction

	// Value bytes extend the trimmed length only when they are not blank.
	function automatic token_t value_char_token(logic [7:0] c);
		token_t t;
		if (value_count >= VALUE_MAX_DEF)
			return error_token(ERR_TOO_LONG);
		t = '0;
		value_count++;
		if (!is_blank_byte(c))
			value_kept = value_count;
		t.kind     = KIND_VAL_CHAR;
		t.char_out = c;
		return t;
	endfunction

	// Advances the parse machine by one transaction; returns 1 when it yields a token.
	function automatic bit tokenize_byte(input item_t it, output token_t tok);
		logic [7:0] c;
		bit         esc;
		c   = it.char_in;
		tok = '0;
		if (it.cmd == CMD_EOF) begin
			tok.kind       = KIND_DONE;
			tok.file_ok    = !error_latched;
			tok.pair_count = pair_total[15:0];
			clear_parser();
			return 1'b1;
		end
		if (error_latched)
			return 1'b0;
		if (!escape_armed && c == CH_BACKSLASH) begin
			escape_armed = 1'b1;
			return 1'b0;
		end
		// Carriage returns vanish even when escaped, and the escape stays armed.
		if (c == CH_CR)
			return 1'b0;
		esc = escape_armed;
		case (scan_state)
			ST_PRE_KEY: begin
				if (esc || is_key_byte(c)) begin
					escape_armed = 1'b0;
					if (esc && c == CH_LF)
						return 1'b0;
					key_count    = 1;
					value_count  = 0;
					value_kept   = 0;
					scan_state   = ST_KEY;
					tok.kind     = KIND_KEY_CHAR;
					tok.char_out = c;
					return 1'b1;
				end
				if (c == CH_LBRACKET) begin
					section_count = 0;
					scan_state    = ST_SECTION;
					tok.kind      = KIND_SECT_START;
					return 1'b1;
				end
				if (c == CH_SEMICOLON || c == CH_HASH)
					scan_state = ST_COMMENT;
				return 1'b0;
			end
			ST_COMMENT: begin
				// An escaped newline carries the comment onto the next line.
				if (c == CH_LF) begin
					if (esc)
						escape_armed = 1'b0;
					else
						scan_state = ST_PRE_KEY;
				end
				return 1'b0;
			end
			ST_KEY: begin
				if (esc || is_key_byte(c)) begin
					escape_armed = 1'b0;
					if (esc && c == CH_LF)
						return 1'b0;
					if (key_count >= KEY_MAX_DEF) begin
						tok = error_token(ERR_TOO_LONG);
						return 1'b1;
					end
					key_count++;
					tok.kind     = KIND_KEY_CHAR;
					tok.char_out = c;
					return 1'b1;
				end
				if (is_blank_byte(c)) begin
					scan_state = ST_POST_KEY;
					return 1'b0;
				end
				if (c == CH_COLON || c == CH_EQUALS) begin
					scan_state = ST_PRE_VAL;
					return 1'b0;
				end
				tok = error_token(ERR_BAD_KEY);
				return 1'b1;
			end
			ST_POST_KEY: begin
				if (c == CH_COLON || c == CH_EQUALS) begin
					scan_state = ST_PRE_VAL;
				end else if (c == CH_LF) begin
					if (!esc) begin
						tok = error_token(ERR_NO_DELIM);
						return 1'b1;
					end
					escape_armed = 1'b0;
				end
				return 1'b0;
			end
			ST_PRE_VAL: begin
				if (esc || (c != CH_LF && c != CH_SEMICOLON && c != CH_HASH
						&& !is_blank_byte(c))) begin
					escape_armed = 1'b0;
					scan_state   = ST_VAL;
					tok          = value_char_token(c);
					return 1'b1;
				end
				if (c == CH_LF) begin
					tok = error_token(ERR_EMPTY_VAL);
					return 1'b1;
				end
				return 1'b0;
			end
			ST_VAL: begin
				if (esc || (c != CH_LF && c != CH_SEMICOLON && c != CH_HASH)) begin
					escape_armed = 1'b0;
					tok          = value_char_token(c);
					return 1'b1;
				end
				// A newline or a comment mark closes the pair.
				tok.kind         = KIND_PAIR_END;
				tok.key_length   = key_count[6:0];
				tok.value_length = value_kept[7:0];
				if (pair_total < PAIR_COUNT_MAX)
					pair_total++;
				key_count   = 0;
				value_count = 0;
				value_kept  = 0;
				scan_state  = (c == CH_LF) ? ST_PRE_KEY : ST_COMMENT;
				return 1'b1;
			end
			ST_SECTION: begin
				if (esc || c != CH_RBRACKET) begin
					escape_armed = 1'b0;
					if (section_count >= SECTION_MAX_DEF) begin
						tok = error_token(ERR_TOO_LONG);
						return 1'b1;
					end
					section_count++;
					tok.kind     = KIND_SECT_CHAR;
					tok.char_out = c;
					return 1'b1;
				end
				scan_state = ST_PRE_KEY;
				tok.kind   = KIND_SECT_END;
				return 1'b1;
			end
			default: begin
				scan_state = ST_PRE_KEY;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: token %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare output transactions, then fold in the input transaction of this edge.
	always @(posedge clk or negedge arst_n) begin
		token_t want;
		token_t made;
		if (!arst_n) begin
			clear_parser();
			tokens_due.delete();
			mismatches       = 0;
			tokens_due_count <= 0;
		end else begin
			if (token_valid && !token_stall) begin
				if (tokens_due.size() == 0) begin
					$display("%0t: unexpected token: expected none, actual %p", $time, token);
					mismatches++;
				end else begin
					want = tokens_due.pop_front();
					check_field("kind", want.kind, token.kind);
					check_field("char_out", want.char_out, token.char_out);
					check_field("key_length", want.key_length, token.key_length);
					check_field("value_length", want.value_length, token.value_length);
					check_field("error_code", want.error_code, token.error_code);
					check_field("file_ok", want.file_ok, token.file_ok);
					check_field("pair_count", want.pair_count, token.pair_count);
				end
			end
			if (item_valid && !item_stall) begin
				if (tokenize_byte(item, made))
					tokens_due.push_back(made);
			end
			tokens_due_count <= tokens_due.size();
		end
	end

endmodule

// ===== verif/tb_ini_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_ini_stream_tokenizer: testbench top of the INI stream tokenizer
// Feeds short INI files byte by byte: two directed files, files at the length
// limits, random well-formed and broken files, and a stretch of clean files
// with no idling. Both sides idle at random elsewhere; the token checker
// beside the block predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_ini_stream_tokenizer;
	import ist_pkg::*;

	localparam int RANDOM_ITEMS   = 60;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	logic   clk;
	logic   arst_n;
	logic   item_valid;
	logic   item_stall;
	item_t  item;
	logic   token_valid;
	logic   token_stall;
	token_t token;
	int     mismatches;
	int     tokens_due_count;

	bit     sender_idles;
	bit     receiver_idles;
	bit     hold_req;
	int     bytes_driven;
	int     quiet_cycles = 0;
	string  key_alphabet =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-.";

	ini_stream_tokenizer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token       (token)
	);

	ist_token_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.item             (item),
		.token_valid      (token_valid),
		.token_stall      (token_stall),
		.token            (token),
		.mismatches       (mismatches),
		.tokens_due_count (tokens_due_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Token receiver: random stalls, and one long hold-off on request.
	initial begin
		token_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				token_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			token_stall <= receiver_idles && ($urandom_range(99) < 35);
		end
	end

	// Watchdog on cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (token_valid && !token_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Offers one input transaction, with an optional idle gap in front of it.
	task automatic drive_item(input item_t it);
		if (sender_idles && $urandom_range(99) < 35) begin
			item_valid <= 1'b0;
			do @(posedge clk); while (sender_idles && $urandom_range(99) < 35);
		end
		item       <= it;
		item_valid <= 1'b1;
		bytes_driven++;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic put_byte(input logic [7:0] c);
		drive_item('{cmd: CMD_BYTE, char_in: c});
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	// The byte that travels with end of file carries no meaning.
	task automatic end_file();
		logic [7:0] junk;
		junk = 8'($urandom_range(255));
		drive_item('{cmd: CMD_EOF, char_in: junk});
	endtask

	function automatic logic [7:0] rand_key_byte();
		return key_alphabet[$urandom_range(key_alphabet.len() - 1)];
	endfunction

	// Plain value text: printable or high bytes, never a comment mark or backslash.
	function automatic logic [7:0] rand_value_byte();
		logic [7:0] c;
		do begin
			if ($urandom_range(99) < 15)
				c = 8'($urandom_range(255, 128));
			else
				c = 8'($urandom_range(126, 32));
		end while (c == CH_SEMICOLON || c == CH_HASH || c == CH_BACKSLASH);
		return c;
	endfunction

	function automatic logic [7:0] rand_section_byte();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(255, 32));
		end while (c == CH_RBRACKET || c == CH_BACKSLASH || c == 8'h7F);
		return c;
	endfunction

	// Backslash followed by a byte that would otherwise steer the parser, or by a random byte.
	task automatic put_escape();
		put_byte(CH_BACKSLASH);
		case ($urandom_range(4))
			0: put_byte(CH_LF);
			1: put_byte(CH_SEMICOLON);
			2: put_byte(CH_HASH);
			3: put_byte(CH_BACKSLASH);
			default: put_byte(8'($urandom_range(255)));
		endcase
	endtask

	task automatic put_key(input int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0: begin
					put_byte(CH_BACKSLASH);
					put_byte(8'($urandom_range(255)));
				end
				1: begin
					// Escaped newline in a key is swallowed.
					put_byte(CH_BACKSLASH);
					put_byte(CH_LF);
					put_byte(rand_key_byte());
				end
				default: put_byte(rand_key_byte());
			endcase
		end
	endtask

	task automatic put_blanks(input int most);
		repeat ($urandom_range(most)) begin
			if ($urandom_range(9) == 0) begin
				put_byte(CH_BACKSLASH);
				put_byte(CH_LF);
			end else begin
				put_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
			end
		end
	endtask

	task automatic put_value(input int n);
		repeat (n) begin
			if ($urandom_range(9) == 0)
				put_escape();
			else
				put_byte(rand_value_byte());
		end
	endtask

	// Comment text may hold a lone backslash or an escaped newline.
	task automatic put_comment();
		put_byte($urandom_range(1) ? CH_SEMICOLON : CH_HASH);
		repeat ($urandom_range(6)) begin
			case ($urandom_range(9))
				0: begin
					put_byte(CH_BACKSLASH);
					put_byte(CH_LF);
				end
				1: put_byte(CH_BACKSLASH);
				default: put_byte(rand_value_byte());
			endcase
		end
		put_byte(CH_LF);
	endtask

	task automatic line_end();
		case ($urandom_range(5))
			0: begin
				put_byte(CH_CR);
				put_byte(CH_LF);
			end
			1: put_comment();
			default: put_byte(CH_LF);
		endcase
	endtask

	task automatic put_section();
		put_byte(CH_LBRACKET);
		repeat ($urandom_range(6)) begin
			if ($urandom_range(7) == 0) begin
				put_byte(CH_BACKSLASH);
				put_byte(CH_RBRACKET);
			end else begin
				put_byte(rand_section_byte());
			end
		end
		put_byte(CH_RBRACKET);
		line_end();
	endtask

	task automatic put_pair();
		put_key($urandom_range(8, 1));
		put_blanks(2);
		put_byte($urandom_range(1) ? CH_EQUALS : CH_COLON);
		put_blanks(2);
		put_value($urandom_range(12, 1));
		put_blanks(2);
		line_end();
	endtask

	// Lines that end the file in an error, and plain noise.
	task automatic put_broken();
		case ($urandom_range(3))
			0: begin
				put_key($urandom_range(4, 1));
				put_byte(rand_value_byte());
				put_byte(CH_LF);
			end
			1: begin
				put_key($urandom_range(4, 1));
				put_byte(CH_SPACE);
				put_blanks(2);
				put_byte(CH_LF);
			end
			2: begin
				put_key($urandom_range(4, 1));
				put_byte(CH_EQUALS);
				repeat ($urandom_range(2)) put_byte(CH_SPACE);
				put_byte(CH_LF);
			end
			default: repeat ($urandom_range(8, 1)) put_byte(8'($urandom_range(255)));
		endcase
	endtask

	task automatic gen_file(input bit clean);
		int r;
		repeat ($urandom_range(10)) begin
			r = $urandom_range(99);
			if (r < 10) begin
				put_section();
			end else if (r < 20) begin
				put_comment();
			end else if (r < 28) begin
				put_blanks(2);
				line_end();
			end else if (!clean && r >= 86) begin
				put_broken();
			end else begin
				put_pair();
			end
		end
		// Some files stop inside a value or with an escape still armed.
		r = $urandom_range(99);
		if (r < 15) begin
			put_key($urandom_range(4, 1));
			put_byte(CH_EQUALS);
			put_value($urandom_range(5, 1));
		end else if (r < 20) begin
			put_byte(CH_BACKSLASH);
		end
		end_file();
	endtask

	initial begin
		int files_start;
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		hold_req       = 1'b0;
		bytes_driven   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Section with a top-bit byte and CR LF, an escaped newline inside a key,
		// an escaped NUL in a value and trailing blanks to trim.
		put_byte(CH_LBRACKET);
		put_byte(8'hFF);
		put_byte(CH_RBRACKET);
		put_byte(CH_CR);
		put_byte(CH_LF);
		put_text("k");
		put_byte(CH_BACKSLASH);
		put_byte(CH_LF);
		put_text("2 = ");
		put_byte(CH_BACKSLASH);
		put_byte(8'h00);
		put_text("v ");
		put_byte(CH_TAB);
		put_byte(CH_LF);
		end_file();
		// A last value with no newline is dropped.
		put_text("a=b");
		end_file();

		// Length limits, while the receiver holds off and the input backs up.
		hold_req = 1'b1;
		put_byte(CH_LBRACKET);
		repeat (SECTION_MAX_DEF) put_byte(rand_section_byte());
		put_byte(CH_RBRACKET);
		put_byte(CH_LF);
		repeat (KEY_MAX_DEF) put_byte(rand_key_byte());
		put_byte(CH_EQUALS);
		repeat (VALUE_MAX_DEF - 1) put_byte(rand_value_byte());
		put_byte(rand_key_byte());
		put_byte(CH_LF);
		end_file();
		repeat (KEY_MAX_DEF + 1) put_byte(rand_key_byte());
		put_text("=x\n");
		end_file();
		put_text("k=");
		repeat (VALUE_MAX_DEF + 1) put_byte(rand_key_byte());
		put_byte(CH_LF);
		end_file();
		put_byte(CH_LBRACKET);
		repeat (SECTION_MAX_DEF + 1) put_byte(rand_section_byte());
		put_byte(CH_RBRACKET);
		end_file();

		// Random files, most of them free of deliberate errors.
		files_start = bytes_driven;
		while (bytes_driven - files_start < RANDOM_ITEMS)
			gen_file($urandom_range(99) < 65);

		// A stretch of clean files with no idling on either side.
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		files_start    = bytes_driven;
		while (bytes_driven - files_start < RANDOM_ITEMS)
			gen_file(1'b1);
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;

		// Drain the remaining tokens, then allow for anything left in flight.
		item_valid <= 1'b0;
		@(posedge clk);
		while (tokens_due_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && tokens_due_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/ist_pkg.sv
hw/rtl/ist_front.sv
hw/rtl/ist_queue.sv
hw/rtl/ist_back.sv
hw/rtl/ini_stream_tokenizer.sv
verif/ist_token_checker.sv
verif/tb_ini_stream_tokenizer.sv
